// ----- rtl/assert_macros.svh -----
// Concurrent assertion helpers for the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked during reset too.
`define ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/bas_pkg.sv -----
package bas_pkg;

    localparam int PERCENT    = 100;
    localparam int COORD_W    = 13;
    localparam int SCALED_W   = 17;
    localparam int DIVIDEND_W = 24;
    localparam int DIVISOR_W  = 16;
    localparam int COUNT_W    = 15;
    localparam int COLOR_W    = 24;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_RENDER = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_ZOOM_PERCENT = 3'd2,
        CFG_PAN_X        = 3'd3,
        CFG_PAN_Y        = 3'd4,
        CFG_VIEW_WIDTH   = 3'd5,
        CFG_VIEW_HEIGHT  = 3'd6,
        CFG_BACKDROP     = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_BOX,
        JOB_FILL
    } job_kind_t;

    typedef struct packed {
        job_kind_t            kind;
        logic [COORD_W-1:0]   x0;
        logic [COORD_W-1:0]   x1;
        logic [COORD_W-1:0]   y0;
        logic [COORD_W-1:0]   y1;
        logic [COLOR_W-1:0]   data;
    } job_t;

    typedef struct packed {
        logic [9:0]  image_width;
        logic [9:0]  image_height;
        logic [10:0] zoom_percent;
        logic [12:0] pan_x;
        logic [12:0] pan_y;
        logic [12:0] view_width;
        logic [12:0] view_height;
        logic [47:0] backdrop_colors;
    } cfg_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_SCALE_X,
        F_SCALE_Y,
        F_PLACE,
        F_DIV_X0,
        F_DIV_Y0,
        F_DIV_X1,
        F_DIV_Y1,
        F_CLIP,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_DRAIN,
        B_DIV_R,
        B_DIV_G,
        B_DIV_B,
        B_OUT
    } back_state_t;

endpackage

// ----- rtl/bas_div.sv -----
module bas_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [bas_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [bas_pkg::DIVISOR_W-1:0]    divisor,
    output logic                             done,
    output logic [bas_pkg::DIVIDEND_W-1:0]   quotient
);
    import bas_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    trial;

    // Restoring division, one quotient bit per cycle, dividend shifted out of quo_reg.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DIVISOR_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/bas_fifo.sv -----
module bas_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bas_pkg::job_t  push_data,
    input  logic           pop,
    output bas_pkg::job_t  pop_data,
    output logic           full,
    output logic           empty
);
    import bas_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];
    assign full     = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty    = (count_reg == '0);

endmodule

// ----- rtl/bas_front.sv -----
module bas_front #(
    parameter int MAX_IMAGE_WIDTH  = 512,
    parameter int MAX_IMAGE_HEIGHT = 512
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  bas_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           in_cmd,
    input  logic [11:0]    in_pos_x,
    input  logic [11:0]    in_pos_y,
    input  logic [23:0]    in_pixel,
    output logic           q_push,
    output bas_pkg::job_t  q_data,
    input  logic           q_full
);
    import bas_pkg::*;

    localparam logic [COORD_W-1:0] MAX_W = COORD_W'(MAX_IMAGE_WIDTH);
    localparam logic [COORD_W-1:0] MAX_H = COORD_W'(MAX_IMAGE_HEIGHT);
    localparam int                 PROD_W      = 21;
    localparam int                 RECIP_SHIFT = 30;
    localparam logic [23:0]        RECIP_100   = 24'd10737419;

    front_state_t          state_reg, state_next;
    logic                  div_run_reg, div_run_next;
    logic [11:0]           px_reg, px_next, py_reg, py_next;
    logic [SCALED_W-1:0]   scaled_x_reg, scaled_x_next, scaled_y_reg, scaled_y_next;
    logic [SCALED_W-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [COORD_W-1:0]    sx0_reg, sx0_next, sx1_reg, sx1_next;
    logic [COORD_W-1:0]    sy0_reg, sy0_next, sy1_reg, sy1_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    job_t                  job_reg, job_next;

    logic [COORD_W-1:0]    w, h, x1_clip, y1_clip;
    logic [10:0]           z;
    logic                  shrink;
    logic                  div_start, div_done;
    logic [DIVIDEND_W-1:0] div_dividend, div_quo;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  cent_x, cent_y, in_x, in_y, odd;
    logic [SCALED_W-1:0]   half_x, half_y;
    logic signed [18:0]    dxs, dys;
    logic                  accept;
    logic [46:0]           scale_prod;
    logic [SCALED_W-1:0]   scale_q;

    bas_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        if (cfg.image_width == '0) begin
            w = COORD_W'(1);
        end else if ({3'b0, cfg.image_width} > MAX_W) begin
            w = MAX_W;
        end else begin
            w = {3'b0, cfg.image_width};
        end
        if (cfg.image_height == '0) begin
            h = COORD_W'(1);
        end else if ({3'b0, cfg.image_height} > MAX_H) begin
            h = MAX_H;
        end else begin
            h = {3'b0, cfg.image_height};
        end
        z      = (cfg.zoom_percent == '0) ? 11'd1 : cfg.zoom_percent;
        shrink = z < 11'(PERCENT);
    end

    // The product stays below 2^21, where the rounded-up reciprocal gives the exact quotient.
    assign scale_prod = 47'(prod_reg) * 47'(RECIP_100);
    assign scale_q    = scale_prod[RECIP_SHIFT +: SCALED_W];

    // Placement: centered when the scaled extent is narrower than the view, else panned.
    always_comb begin
        cent_x = scaled_x_reg < {4'b0, cfg.view_width};
        cent_y = scaled_y_reg < {4'b0, cfg.view_height};
        half_x = SCALED_W'({4'b0, cfg.view_width} - scaled_x_reg) >> 1;
        half_y = SCALED_W'({4'b0, cfg.view_height} - scaled_y_reg) >> 1;
        dxs = cent_x ? ($signed({7'b0, px_reg}) - $signed({2'b0, half_x}))
                     : ($signed({7'b0, px_reg}) + $signed({6'b0, cfg.pan_x}));
        dys = cent_y ? ($signed({7'b0, py_reg}) - $signed({2'b0, half_y}))
                     : ($signed({7'b0, py_reg}) + $signed({6'b0, cfg.pan_y}));
        in_x = !dxs[18] && (dxs[17:0] < {1'b0, scaled_x_reg});
        in_y = !dys[18] && (dys[17:0] < {1'b0, scaled_y_reg});
        odd  = px_reg[4] ^ py_reg[4];
        x1_clip = (sx1_reg > w) ? w : sx1_reg;
        if (x1_clip <= sx0_reg) begin
            x1_clip = sx0_reg + 1'b1;
        end
        y1_clip = (sy1_reg > h) ? h : sy1_reg;
        if (y1_clip <= sy0_reg) begin
            y1_clip = sy0_reg + 1'b1;
        end
    end

    always_comb begin
        unique case (state_reg)
            F_DIV_X0:  div_dividend = DIVIDEND_W'(dx_reg) * DIVIDEND_W'(PERCENT);
            F_DIV_Y0:  div_dividend = DIVIDEND_W'(dy_reg) * DIVIDEND_W'(PERCENT);
            F_DIV_X1:  div_dividend = DIVIDEND_W'(dx_reg + 1'b1) * DIVIDEND_W'(PERCENT);
            F_DIV_Y1:  div_dividend = DIVIDEND_W'(dy_reg + 1'b1) * DIVIDEND_W'(PERCENT);
            default:   div_dividend = '0;
        endcase
        div_divisor = DIVISOR_W'(z);
    end

    assign in_ready = (state_reg == F_IDLE) && !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next    = state_reg;
        div_run_next  = div_run_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        scaled_x_next = scaled_x_reg;
        scaled_y_next = scaled_y_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        sx0_next      = sx0_reg;
        sx1_next      = sx1_reg;
        sy0_next      = sy0_reg;
        sy1_next      = sy1_reg;
        prod_next     = prod_reg;
        job_next      = job_reg;
        div_start     = 1'b0;
        q_push        = 1'b0;
        q_data        = job_reg;

        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    px_next = in_pos_x;
                    py_next = in_pos_y;
                    if (in_cmd == CMD_RENDER) begin
                        state_next = F_SCALE_X;
                    end else if ({1'b0, in_pos_x} < MAX_W && {1'b0, in_pos_y} < MAX_H) begin
                        // Writes beyond the storage are dropped here.
                        q_push      = 1'b1;
                        q_data.kind = JOB_WRITE;
                        q_data.x0   = {1'b0, in_pos_x};
                        q_data.x1   = {1'b0, in_pos_x};
                        q_data.y0   = {1'b0, in_pos_y};
                        q_data.y1   = {1'b0, in_pos_y};
                        q_data.data = in_pixel;
                    end
                end
            end
            F_SCALE_X, F_SCALE_Y: begin
                // The product is registered first, then scaled down by 100 from the register.
                if (!div_run_reg) begin
                    prod_next    = (state_reg == F_SCALE_X) ? PROD_W'(w) * PROD_W'(z)
                                                            : PROD_W'(h) * PROD_W'(z);
                    div_run_next = 1'b1;
                end else begin
                    div_run_next = 1'b0;
                    if (state_reg == F_SCALE_X) begin
                        scaled_x_next = scale_q;
                        state_next    = F_SCALE_Y;
                    end else begin
                        scaled_y_next = scale_q;
                        state_next    = F_PLACE;
                    end
                end
            end
            F_DIV_X0, F_DIV_Y0, F_DIV_X1, F_DIV_Y1: begin
                if (!div_run_reg) begin
                    div_start    = 1'b1;
                    div_run_next = 1'b1;
                end else if (div_done) begin
                    div_run_next = 1'b0;
                    unique case (state_reg)
                        F_DIV_X0: begin
                            sx0_next   = div_quo[COORD_W-1:0];
                            state_next = F_DIV_Y0;
                        end
                        F_DIV_Y0: begin
                            sy0_next = div_quo[COORD_W-1:0];
                            if (shrink) begin
                                state_next = F_DIV_X1;
                            end else begin
                                sx1_next   = sx0_reg + 1'b1;
                                sy1_next   = div_quo[COORD_W-1:0] + 1'b1;
                                state_next = F_CLIP;
                            end
                        end
                        F_DIV_X1: begin
                            sx1_next   = div_quo[COORD_W-1:0];
                            state_next = F_DIV_Y1;
                        end
                        default: begin
                            sy1_next   = div_quo[COORD_W-1:0];
                            state_next = F_CLIP;
                        end
                    endcase
                end
            end
            F_PLACE: begin
                dx_next = dxs[SCALED_W-1:0];
                dy_next = dys[SCALED_W-1:0];
                if (in_x && in_y) begin
                    state_next = F_DIV_X0;
                end else begin
                    job_next.kind = JOB_FILL;
                    job_next.data = odd ? cfg.backdrop_colors[47:24]
                                        : cfg.backdrop_colors[23:0];
                    state_next    = F_PUSH;
                end
            end
            F_CLIP: begin
                job_next.kind = JOB_BOX;
                job_next.x0   = sx0_reg;
                job_next.x1   = x1_clip;
                job_next.y0   = sy0_reg;
                job_next.y1   = y1_clip;
                state_next    = F_PUSH;
            end
            F_PUSH: begin
                if (!q_full) begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            div_run_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            div_run_reg <= div_run_next;
        end
        px_reg       <= px_next;
        py_reg       <= py_next;
        scaled_x_reg <= scaled_x_next;
        scaled_y_reg <= scaled_y_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        sx0_reg      <= sx0_next;
        sx1_reg      <= sx1_next;
        sy0_reg      <= sy0_next;
        sy1_reg      <= sy1_next;
        prod_reg     <= prod_next;
        job_reg      <= job_next;
    end

endmodule

// ----- rtl/bas_back.sv -----
module bas_back #(
    parameter int MAX_IMAGE_WIDTH  = 512,
    parameter int MAX_IMAGE_HEIGHT = 512
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  bas_pkg::job_t  q_data,
    input  logic           q_empty,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [23:0]    out_pixel,
    output logic           out_backdrop
);
    import bas_pkg::*;

    localparam int DEPTH  = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [COLOR_W-1:0] mem [DEPTH];

    back_state_t          state_reg, state_next;
    job_t                 job_reg, job_next;
    logic [COORD_W-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic [ADDR_W-1:0]    row_reg, row_next;
    logic [COUNT_W-1:0]   n_reg, n_next;
    logic [DIVIDEND_W-1:0] sum_r_reg, sum_r_next, sum_g_reg, sum_g_next;
    logic [DIVIDEND_W-1:0] sum_b_reg, sum_b_next;
    logic [7:0]           avg_r_reg, avg_r_next, avg_g_reg, avg_g_next;
    logic                 div_run_reg, div_run_next;
    logic                 rvalid_reg;
    logic [COLOR_W-1:0]   rdata_reg;
    logic [COLOR_W-1:0]   res_pixel_reg, res_pixel_next;
    logic                 res_bd_reg, res_bd_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]   out_pixel_reg, out_pixel_next;
    logic                 out_bd_reg, out_bd_next;

    logic                 rd_en, wr_en;
    logic [ADDR_W-1:0]    rd_addr, wr_addr;
    logic                 div_start, div_done;
    logic [DIVIDEND_W-1:0] div_dividend, div_quo;

    bas_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  ({1'b0, n_reg}),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign wr_addr = ADDR_W'(q_data.y0) * ADDR_W'(MAX_IMAGE_WIDTH) + ADDR_W'(q_data.x0);
    assign rd_addr = row_reg + ADDR_W'(cx_reg);

    always_comb begin
        case (state_reg)
            B_DIV_R: div_dividend = sum_r_reg;
            B_DIV_G: div_dividend = sum_g_reg;
            default: div_dividend = sum_b_reg;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        job_next       = job_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        row_next       = row_reg;
        n_next         = n_reg;
        sum_r_next     = sum_r_reg;
        sum_g_next     = sum_g_reg;
        sum_b_next     = sum_b_reg;
        avg_r_next     = avg_r_reg;
        avg_g_next     = avg_g_reg;
        div_run_next   = div_run_reg;
        res_pixel_next = res_pixel_reg;
        res_bd_next    = res_bd_reg;
        out_valid_next = out_valid_reg;
        out_pixel_next = out_pixel_reg;
        out_bd_next    = out_bd_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        div_start      = 1'b0;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        // Read data comes from a registered memory read and trails its address.
        if (rvalid_reg) begin
            sum_r_next = sum_r_reg + DIVIDEND_W'(rdata_reg[23:16]);
            sum_g_next = sum_g_reg + DIVIDEND_W'(rdata_reg[15:8]);
            sum_b_next = sum_b_reg + DIVIDEND_W'(rdata_reg[7:0]);
        end

        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    job_next = q_data;
                    unique case (q_data.kind)
                        JOB_WRITE: wr_en = 1'b1;
                        JOB_FILL: begin
                            res_pixel_next = q_data.data;
                            res_bd_next    = 1'b1;
                            state_next     = B_OUT;
                        end
                        default: begin
                            cx_next    = q_data.x0;
                            cy_next    = q_data.y0;
                            row_next   = ADDR_W'(q_data.y0) * ADDR_W'(MAX_IMAGE_WIDTH);
                            n_next     = '0;
                            sum_r_next = '0;
                            sum_g_next = '0;
                            sum_b_next = '0;
                            state_next = B_SCAN;
                        end
                    endcase
                end
            end
            B_SCAN: begin
                rd_en  = 1'b1;
                n_next = n_reg + 1'b1;
                if (cx_reg + 1'b1 == job_reg.x1) begin
                    cx_next  = job_reg.x0;
                    cy_next  = cy_reg + 1'b1;
                    row_next = row_reg + ADDR_W'(MAX_IMAGE_WIDTH);
                    if (cy_reg + 1'b1 == job_reg.y1) begin
                        state_next = B_DRAIN;
                    end
                end else begin
                    cx_next = cx_reg + 1'b1;
                end
            end
            B_DRAIN: state_next = B_DIV_R;
            B_DIV_R, B_DIV_G, B_DIV_B: begin
                if (!div_run_reg) begin
                    div_start    = 1'b1;
                    div_run_next = 1'b1;
                end else if (div_done) begin
                    div_run_next = 1'b0;
                    unique case (state_reg)
                        B_DIV_R: begin
                            avg_r_next = div_quo[7:0];
                            state_next = B_DIV_G;
                        end
                        B_DIV_G: begin
                            avg_g_next = div_quo[7:0];
                            state_next = B_DIV_B;
                        end
                        default: begin
                            res_pixel_next = {avg_r_reg, avg_g_reg, div_quo[7:0]};
                            res_bd_next    = 1'b0;
                            state_next     = B_OUT;
                        end
                    endcase
                end
            end
            B_OUT: begin
                // The result waits here until the output register has been taken.
                if (!out_valid_reg) begin
                    out_valid_next = 1'b1;
                    out_pixel_next = res_pixel_reg;
                    out_bd_next    = res_bd_reg;
                    state_next     = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= q_data.data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            div_run_reg   <= 1'b0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_run_reg   <= div_run_next;
            rvalid_reg    <= rd_en;
            out_valid_reg <= out_valid_next;
        end
        job_reg       <= job_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        row_reg       <= row_next;
        n_reg         <= n_next;
        sum_r_reg     <= sum_r_next;
        sum_g_reg     <= sum_g_next;
        sum_b_reg     <= sum_b_next;
        avg_r_reg     <= avg_r_next;
        avg_g_reg     <= avg_g_next;
        res_pixel_reg <= res_pixel_next;
        res_bd_reg    <= res_bd_next;
        out_pixel_reg <= out_pixel_next;
        out_bd_reg    <= out_bd_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_pixel    = out_pixel_reg;
    assign out_backdrop = out_bd_reg;

endmodule

// ----- rtl/box_average_image_scaler_unit.sv -----
// Write item: taken from the input, queued and stored in the image memory when the back is
// idle; no result. Render item: the front works out the scaled extent and placement, then
// runs two (nearest) or four (box average) serial 24-step divides and queues the job; a
// backdrop render skips the divides. The back then reads each box pixel once, runs three
// divides for the color averages and outputs the result; a backdrop goes straight to output.
// A new item is taken only while the front is idle and the queue has room.
// Reset (aresetn low, synchronous) restores the register defaults and empties the queue and
// the output; the image memory keeps no reset value and needs no clearing.
`include "assert_macros.svh"

module box_average_image_scaler_unit #(
    parameter int MAX_IMAGE_WIDTH  = 512,
    parameter int MAX_IMAGE_HEIGHT = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x [11:0], pos_y [23:12], pixel_in [47:24]
    input  logic [0:0]  s_tuser,   // cmd [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pixel_out [23:0]
    output logic [0:0]  m_tuser,   // is_backdrop [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import bas_pkg::*;

    cfg_t cfg_reg, cfg_next;
    job_t q_in, q_out;
    logic q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  cfg_next.image_width     = cfg_data[9:0];
                CFG_IMAGE_HEIGHT: cfg_next.image_height    = cfg_data[9:0];
                CFG_ZOOM_PERCENT: cfg_next.zoom_percent    = cfg_data[10:0];
                CFG_PAN_X:        cfg_next.pan_x           = cfg_data[12:0];
                CFG_PAN_Y:        cfg_next.pan_y           = cfg_data[12:0];
                CFG_VIEW_WIDTH:   cfg_next.view_width      = cfg_data[12:0];
                CFG_VIEW_HEIGHT:  cfg_next.view_height     = cfg_data[12:0];
                default:          cfg_next.backdrop_colors = cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width     <= 10'd512;
            cfg_reg.image_height    <= 10'd512;
            cfg_reg.zoom_percent    <= 11'd100;
            cfg_reg.pan_x           <= '0;
            cfg_reg.pan_y           <= '0;
            cfg_reg.view_width      <= 13'd640;
            cfg_reg.view_height     <= 13'd480;
            cfg_reg.backdrop_colors <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    bas_front #(
        .MAX_IMAGE_WIDTH  (MAX_IMAGE_WIDTH),
        .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser[0]),
        .in_pos_x (s_tdata[11:0]),
        .in_pos_y (s_tdata[23:12]),
        .in_pixel (s_tdata[47:24]),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_full   (q_full)
    );

    bas_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    bas_back #(
        .MAX_IMAGE_WIDTH  (MAX_IMAGE_WIDTH),
        .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_data       (q_out),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_pixel    (m_tdata),
        .out_backdrop (m_tuser[0])
    );

    `ASSERT_SAME(a_no_push_when_full, aclk, aresetn, q_push, !q_full)
    `ASSERT_SAME(a_no_pop_when_empty, aclk, aresetn, q_pop, !q_empty)
    `ASSERT_NEXT(a_reset_clears_output, aclk, !aresetn, !m_tvalid)

endmodule
